// ===== rtl/sliding_window_trimmed_mean_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window trimmed mean: shared assertion macros
// Concurrent assertion helpers; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_TRIMMED_MEAN_DEFINES_SVH
`define SLIDING_WINDOW_TRIMMED_MEAN_DEFINES_SVH

// same-cycle implication
`define SWTM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWTM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/swtm_pkg.sv =====
// ----------------------------------------------------------------------------
// swtm_pkg
// Types and fixed constants of the sliding window trimmed mean block.
// ----------------------------------------------------------------------------
package swtm_pkg;

    localparam int VAL_W     = 27;

    typedef logic [VAL_W-1:0] val_t;

    localparam val_t MIN_VALUE_RST = 27'd100;
    localparam val_t MAX_VALUE_RST = 27'd100000000;

    typedef logic cfg_idx_t;
    localparam cfg_idx_t CFG_MIN_VALUE = 1'b0;
    localparam cfg_idx_t CFG_MAX_VALUE = 1'b1;

    typedef struct packed {
        val_t sample;
    } sample_beat_t;

    typedef struct packed {
        logic accepted;
        logic trimmed;
        val_t mean_value;
    } mean_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RANK,
        ST_DRAIN,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;        // latch incoming sample
        logic check;       // latch result flags, clear sum
        logic shift_in;    // push sample into window
        logic clear_step;  // zero step counter
        logic rank_step;   // rank candidate, rotate window
        logic div_load;    // load dividend from final sum
        logic div_step;    // reciprocal multiply, latch quotient
        logic load_out;    // load output register
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic full;
        logic rank_last;
        logic div_last;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/swtm_stream_if.sv =====
// ----------------------------------------------------------------------------
// swtm_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface swtm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sliding_window_trimmed_mean.sv =====
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean
// Range-gated sliding window; trimmed mean over the middle ranks once full.
// ----------------------------------------------------------------------------
// channel   dir  payload                                 beat
// samples   in   sample[26:0]                            one sample
// means     out  accepted, trimmed, mean_value[26:0]     one result per sample
// cfg_*     in   cfg_idx (0 min_value, 1 max_value)      write on cfg_wen
//
// Rejected or filling sample: take, check, emit, then ready again.
// Trimmed sample: take, check, ranking pass, drain, divide, emit. The ranking
//   pass takes one window entry per cycle; the divide by KEEP_COUNT is a
//   single reciprocal multiply.
// Reset clears control and the fill count and loads the default range; no clearing pass.
// A finished result waits in the output register; the next sample is taken
// meanwhile and holds in the emit step only if that register is still full.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean #(
    parameter int WINDOW_DEPTH = 21,  // 3..64
    parameter int SKIP_LOW     = 6,   // 0..30
    parameter int KEEP_COUNT   = 9    // 1..64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  swtm_pkg::cfg_idx_t cfg_idx,
    input  swtm_pkg::val_t     cfg_wdata,
    swtm_stream_if.sink        samples,
    swtm_stream_if.source      means
);
    import swtm_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    in_ready;

    // sample channel handshake is owned by the sequencer
    assign samples.ready = in_ready;

    swtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // window, ranking, accumulation, divider and output register
    swtm_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SKIP_LOW     (SKIP_LOW),
        .KEEP_COUNT   (KEEP_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .sample    (samples.data.sample),
        .cmd       (cmd),
        .sts       (sts),
        .means     (means)
    );

endmodule

// ===== rtl/swtm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swtm_ctrl
// Sequencer: accept, range check, ranking pass, divide, emit.
// ----------------------------------------------------------------------------
module swtm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  swtm_pkg::dp_sts_t sts,
    output swtm_pkg::dp_cmd_t cmd
);
    import swtm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.in_range)
                begin
                    cmd.shift_in = 1'b1;
                end
                if (sts.in_range && sts.full)
                begin
                    cmd.clear_step = 1'b1;
                    state_next     = ST_RANK;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_RANK:
            begin
                cmd.rank_step = 1'b1;
                if (sts.rank_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.div_load   = 1'b1;
                cmd.clear_step = 1'b1;
                state_next     = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/swtm_dp.sv =====
// ----------------------------------------------------------------------------
// swtm_dp
// Window shift line, serial rank/accumulate, reciprocal divide, output reg.
// ----------------------------------------------------------------------------
`include "sliding_window_trimmed_mean_defines.svh"

module swtm_dp #(
    parameter int WINDOW_DEPTH = 21,
    parameter int SKIP_LOW     = 6,
    parameter int KEEP_COUNT   = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  swtm_pkg::cfg_idx_t cfg_idx,
    input  swtm_pkg::val_t     cfg_wdata,
    input  swtm_pkg::val_t     sample,
    input  swtm_pkg::dp_cmd_t  cmd,
    output swtm_pkg::dp_sts_t  sts,
    swtm_stream_if.source      means
);
    import swtm_pkg::*;

    localparam int CNT_W    = $clog2(WINDOW_DEPTH);
    localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W    = VAL_W + $clog2(KEEP_COUNT + 1);
    localparam int DIV_CYC  = 1;   // divide is a single reciprocal multiply
    // floor(x / KEEP_COUNT) == (x * ceil(2^RCP_SH / KEEP_COUNT)) >> RCP_SH
    // holds for every x below 2^SUM_W
    localparam int RCP_SH   = SUM_W + $clog2(KEEP_COUNT);
    localparam int RCP_W    = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_MUL =
        RCP_W'(((64'd1 << RCP_SH) + 64'(KEEP_COUNT) - 64'd1) / 64'(KEEP_COUNT));
    localparam int STEP_MAX = (WINDOW_DEPTH > DIV_CYC) ? WINDOW_DEPTH : DIV_CYC;
    localparam int STEP_W   = $clog2(STEP_MAX);
    localparam int RANK_END = SKIP_LOW + KEEP_COUNT;

    val_t                    min_reg;
    val_t                    max_reg;
    val_t                    sample_reg;
    val_t                    win_reg [WINDOW_DEPTH];
    logic [FILL_W-1:0]       fill_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    acc_flag_reg;
    logic                    trim_flag_reg;
    logic [WINDOW_DEPTH-1:0] hits_reg;
    logic [WINDOW_DEPTH-1:0] hits_next;
    val_t                    cand_reg;
    logic                    a_valid_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic [SUM_W-1:0]        div_reg;
    logic [PROD_W-1:0]       prod;
    val_t                    quo_reg;
    logic                    out_valid_reg;
    mean_beat_t              out_data_reg;
    mean_beat_t              out_data_next;
    logic [CNT_W-1:0]        rank_cnt;
    logic                    in_keep;
    logic                    in_range;
    logic                    full;
    logic                    fill_inc;

    assign in_range = (sample_reg >= min_reg) && (sample_reg <= max_reg);
    assign full     = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign fill_inc = cmd.shift_in && !full;

    assign sts.in_range  = in_range;
    assign sts.full      = full;
    assign sts.rank_last = (step_reg == STEP_W'(WINDOW_DEPTH - 1));
    assign sts.div_last  = (step_reg == STEP_W'(DIV_CYC - 1));
    assign sts.out_free  = !out_valid_reg || means.ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_VALUE_RST;
            max_reg <= MAX_VALUE_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_idx)
                CFG_MIN_VALUE: min_reg <= cfg_wdata;
                CFG_MAX_VALUE: max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // candidate sits in slot 0; slots 1..step were candidates already,
    // so ties against them count toward the rank (unique ranks)
    always_comb
    begin
        hits_next[0] = 1'b0;
        for (int j = 1; j < WINDOW_DEPTH; j++)
        begin
            hits_next[j] = (win_reg[j] < win_reg[0]) ||
                           ((win_reg[j] == win_reg[0]) && (STEP_W'(j) <= step_reg));
        end
    end

    always_comb
    begin
        rank_cnt = '0;
        for (int j = 0; j < WINDOW_DEPTH; j++)
        begin
            rank_cnt = rank_cnt + CNT_W'(hits_reg[j]);
        end
    end

    assign in_keep  = (int'(rank_cnt) >= SKIP_LOW) && (int'(rank_cnt) < RANK_END);
    assign sum_next = sum_reg + ((a_valid_reg && in_keep) ? SUM_W'(cand_reg) : '0);

    // divide by KEEP_COUNT as a reciprocal multiply
    assign prod = PROD_W'(div_reg) * PROD_W'(RCP_MUL);

    always_comb
    begin
        out_data_next.accepted = acc_flag_reg;
        out_data_next.trimmed  = trim_flag_reg;
        if (trim_flag_reg)
        begin
            out_data_next.mean_value = quo_reg;
        end
        else if (acc_flag_reg)
        begin
            out_data_next.mean_value = sample_reg;
        end
        else
        begin
            out_data_next.mean_value = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            step_reg      <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fill_inc)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.clear_step)
            begin
                step_reg <= '0;
            end
            else if (cmd.rank_step || cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            a_valid_reg <= cmd.rank_step;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (means.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sample_reg <= sample;
        end
        if (cmd.check)
        begin
            acc_flag_reg  <= in_range;
            trim_flag_reg <= in_range && full;
        end
        if (cmd.shift_in || cmd.rank_step)
        begin
            win_reg[0] <= cmd.shift_in ? sample_reg : win_reg[WINDOW_DEPTH-1];
            for (int j = 1; j < WINDOW_DEPTH; j++)
            begin
                win_reg[j] <= win_reg[j-1];
            end
        end
        hits_reg <= hits_next;
        cand_reg <= win_reg[0];
        if (cmd.check)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
        if (cmd.div_load)
        begin
            div_reg <= sum_next;
        end
        if (cmd.div_step)
        begin
            quo_reg <= prod[RCP_SH +: VAL_W];
        end
        if (cmd.load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign means.valid = out_valid_reg;
    assign means.data  = out_data_reg;

    `SWTM_ASSERT_IMP(a_load_free, cmd.load_out, !out_valid_reg || means.ready, "result overwritten")
    `SWTM_ASSERT_IMP(a_rank_full, cmd.rank_step, full, "ranking on partial window")
    `SWTM_ASSERT_IMP(a_div_drained, cmd.div_step, !a_valid_reg, "divide before sum settled")
    `SWTM_ASSERT_NXT(a_fill_step, fill_inc, fill_reg == $past(fill_reg) + 1'b1, "fill count slip")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: sliding_window_trimmed_mean testbench
// A short directed table (range edges, reject cases, window fill, first trimmed
// means), then random samples over several min/max range settings. The
// expected result of every sample beat is typed into the table or comes from a
// local window model, and is compared field by field with each result beat.
// ----------------------------------------------------------------------------
module tb;

    import swtm_pkg::*;

    // Window geometry, matching the block's default parameters
    localparam int WIN_DEPTH = 21;
    localparam int SKIP_LOW  = 6;
    localparam int KEEP      = 9;

    // Watchdog.
    localparam int LIMIT_CYCLES = 1000000;

    localparam val_t VAL_ALL_ONES = '1;

    // Idle profiles: who stalls and how often (percent of cycles)
    typedef enum int {
        IDLE_SEND_LIGHT,  // sender 33, receiver 56
        IDLE_SEND_HEAVY,  // sender 56, receiver 33
        IDLE_NONE
    } idle_mode_t;

    // One directed row: the sample and, where it is obvious, the result
    typedef struct {
        val_t       sample;
        bit         typed;
        mean_beat_t want;
    } dir_row_t;

    // One random phase: range setting, number of samples, idle profile
    typedef struct {
        val_t       lo;
        val_t       hi;
        int         count;
        idle_mode_t mode;
    } phase_t;

    logic clk;
    logic rst_n;
    logic cfg_wen;
    cfg_idx_t cfg_idx;
    val_t cfg_wdata;

    swtm_stream_if #(.payload_t(sample_beat_t)) sample_ch ();
    swtm_stream_if #(.payload_t(mean_beat_t))   mean_ch ();

    sliding_window_trimmed_mean u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .samples   (sample_ch),
        .means     (mean_ch)
    );

    // ------------------------------------------------------------------------
    // Window model: range limits, sample history, fill count, oldest slot
    // ------------------------------------------------------------------------
    val_t lim_lo;
    val_t lim_hi;
    val_t window_hist [WIN_DEPTH];
    int   hist_fill;
    int   hist_oldest;

    mean_beat_t pending_means [$];   // results still owed by the block

    int fail_count;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;

    // Directed table. Rejects and filling echoes are typed in; the trimmed
    // rows (after the 21st accepted sample) go through the model.
    dir_row_t dir_rows [27] = '{
        '{27'd0,         1'b1, '{1'b0, 1'b0, 27'd0}},          // below min
        '{27'd100,       1'b1, '{1'b1, 1'b0, 27'd100}},        // min edge
        '{27'd100000000, 1'b1, '{1'b1, 1'b0, 27'd100000000}},  // max edge
        '{27'd100000001, 1'b1, '{1'b0, 1'b0, 27'd0}},          // just above max
        '{VAL_ALL_ONES,  1'b1, '{1'b0, 1'b0, 27'd0}},          // field max
        '{27'd250,       1'b1, '{1'b1, 1'b0, 27'd250}},
        '{27'd250,       1'b1, '{1'b1, 1'b0, 27'd250}},
        '{27'd250,       1'b1, '{1'b1, 1'b0, 27'd250}},
        '{27'd1000,      1'b1, '{1'b1, 1'b0, 27'd1000}},
        '{27'd99999,     1'b1, '{1'b1, 1'b0, 27'd99999}},
        '{27'd7777777,   1'b1, '{1'b1, 1'b0, 27'd7777777}},
        '{27'd100,       1'b1, '{1'b1, 1'b0, 27'd100}},
        '{27'd42424242,  1'b1, '{1'b1, 1'b0, 27'd42424242}},
        '{27'd3141592,   1'b1, '{1'b1, 1'b0, 27'd3141592}},
        '{27'd250,       1'b1, '{1'b1, 1'b0, 27'd250}},
        '{27'd65536,     1'b1, '{1'b1, 1'b0, 27'd65536}},
        '{27'd8388608,   1'b1, '{1'b1, 1'b0, 27'd8388608}},
        '{27'd100000000, 1'b1, '{1'b1, 1'b0, 27'd100000000}},
        '{27'd12000,     1'b1, '{1'b1, 1'b0, 27'd12000}},
        '{27'd12000,     1'b1, '{1'b1, 1'b0, 27'd12000}},
        '{27'd500000,    1'b1, '{1'b1, 1'b0, 27'd500000}},
        '{27'd2718281,   1'b1, '{1'b1, 1'b0, 27'd2718281}},
        '{27'd333,       1'b1, '{1'b1, 1'b0, 27'd333}},
        '{27'd60000000,  1'b1, '{1'b1, 1'b0, 27'd60000000}},   // fills last slot
        '{27'd100,       1'b0, '{1'b0, 1'b0, 27'd0}},          // first trimmed
        '{27'd99999999,  1'b0, '{1'b0, 1'b0, 27'd0}},
        '{27'd99,        1'b1, '{1'b0, 1'b0, 27'd0}}           // reject when full
    };

    // Random phases: full range, narrow, inverted, reset values, single
    // value at each end, then wide again. Window contents carry across.
    phase_t phases [8] = '{
        '{27'd0,         VAL_ALL_ONES,    300, IDLE_SEND_LIGHT},
        '{27'd1000,      27'd2000,        250, IDLE_SEND_LIGHT},
        '{27'd5000,      27'd10,           40, IDLE_SEND_HEAVY},
        '{MIN_VALUE_RST, MAX_VALUE_RST,   300, IDLE_SEND_HEAVY},
        '{VAL_ALL_ONES,  VAL_ALL_ONES,     60, IDLE_SEND_HEAVY},
        '{27'd0,         27'd0,            60, IDLE_NONE},
        '{27'd0,         27'd50000,       300, IDLE_NONE},
        '{27'd0,         VAL_ALL_ONES,    240, IDLE_NONE}
    };

    // Rank the full window ascending, sum the kept middle ranks, truncate
    function automatic val_t window_trimmed_mean();
        val_t ranked [WIN_DEPTH];
        val_t v;
        int j;
        longint unsigned acc;
        ranked = window_hist;
        acc = 0;
        for (int i = 1; i < WIN_DEPTH; i++)
        begin
            v = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > v)
            begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = v;
        end
        for (int k = 0; k < KEEP; k++)
        begin
            if (SKIP_LOW + k < WIN_DEPTH)
                acc += ranked[SKIP_LOW + k];
        end
        return val_t'(acc / KEEP);
    endfunction

    // Advance the window model by one sample and return the expected result
    function automatic mean_beat_t predict_mean(val_t s);
        mean_beat_t r;
        r = '0;
        // out of range (also covers an inverted range): state untouched
        if (s < lim_lo || s > lim_hi)
            return r;
        r.accepted = 1'b1;
        if (hist_fill < WIN_DEPTH)
        begin
            // still filling: append and echo, even for the filling sample
            window_hist[hist_fill] = s;
            hist_fill++;
            r.mean_value = s;
        end
        else
        begin
            window_hist[hist_oldest] = s;
            hist_oldest = (hist_oldest + 1) % WIN_DEPTH;
            r.trimmed = 1'b1;
            r.mean_value = window_trimmed_mean();
        end
        return r;
    endfunction

    // Random sample for a range: mostly in range (with ties near the low
    // end), some range edges and their neighbors, some raw 27-bit noise
    function automatic val_t gen_sample(val_t lo, val_t hi);
        int roll;
        int unsigned span;
        roll = $urandom_range(0, 99);
        if (roll < 20 || lo > hi)
        begin
            if (lo > hi && roll >= 20 && roll < 40)
                return ($urandom_range(0, 1) != 0) ? lo : hi;
            return val_t'($urandom);
        end
        if (roll < 30)
        begin
            case ($urandom_range(0, 3))
                0: return lo;
                1: return hi;
                2: return lo - 1'b1;
                default: return hi + 1'b1;
            endcase
        end
        if (roll < 45)
        begin
            span = hi - lo;
            return lo + val_t'($urandom_range(0, (span < 3) ? span : 3));
        end
        return val_t'($urandom_range(lo, hi));
    endfunction

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sliding_window_trimmed_mean test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_SEND_LIGHT:
            begin
                send_idle_pct = 33;
                recv_idle_pct = 56;
            end
            IDLE_SEND_HEAVY:
            begin
                send_idle_pct = 56;
                recv_idle_pct = 33;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one sample beat, optionally after an idle gap. Valid is left
    // high so back-to-back beats are offered with no gap in valid. The model
    // advances on the edge where the beat is taken.
    task automatic send_sample(val_t s, bit typed, mean_beat_t want);
        int gap;
        mean_beat_t pred;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            // mostly short gaps; now and then one long enough to land
            // anywhere in the rank and divide pass
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 40)
                                              : $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= '{sample: s};
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pred = predict_mean(s);
        pending_means.push_back(typed ? want : pred);
    endtask

    // Stop offering beats until every owed result has come out, then hold
    // off for a margin. Always waits on the clock, even with nothing owed.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_means.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write both range registers on consecutive edges; block must be idle
    task automatic set_range(val_t lo, val_t hi);
        cfg_wen   <= 1'b1;
        cfg_idx   <= CFG_MIN_VALUE;
        cfg_wdata <= lo;
        @(posedge clk);
        lim_lo    = lo;
        cfg_idx   <= CFG_MAX_VALUE;
        cfg_wdata <= hi;
        @(posedge clk);
        lim_hi    = hi;
        cfg_wen   <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_wen         <= 1'b0;
        cfg_idx         <= CFG_MIN_VALUE;
        cfg_wdata       <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.data  <= '0;
        fail_count      = 0;
        lim_lo          = MIN_VALUE_RST;
        lim_hi          = MAX_VALUE_RST;
        hist_fill       = 0;
        hist_oldest     = 0;
        set_idle(IDLE_SEND_LIGHT);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset range
        foreach (dir_rows[i])
            send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);

        // Random phases; range writes only with the block drained
        foreach (phases[p])
        begin
            set_idle(phases[p].mode);
            drain_results();
            set_range(phases[p].lo, phases[p].hi);
            for (int n = 0; n < phases[p].count; n++)
            begin
                // occasional hold-off until the block has caught up
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                send_sample(gen_sample(phases[p].lo, phases[p].hi), 1'b0, '0);
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("sliding_window_trimmed_mean test passed");
        else
            $display("sliding_window_trimmed_mean test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver side: random ready, in-order check of each result beat
    // ------------------------------------------------------------------------
    initial
    begin
        mean_beat_t got;
        mean_beat_t exp_beat;
        mean_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && mean_ch.valid && mean_ch.ready)
            begin
                got = mean_ch.data;
                if (pending_means.size() == 0)
                begin
                    $display("%0t: unexpected result beat: accepted %0d trimmed %0d mean %0d",
                             $time, got.accepted, got.trimmed, got.mean_value);
                    fail_count++;
                end
                else
                begin
                    exp_beat = pending_means.pop_front();
                    if (got.accepted !== exp_beat.accepted)
                    begin
                        $display("%0t: accepted mismatch: expected %0d, actual %0d",
                                 $time, exp_beat.accepted, got.accepted);
                        fail_count++;
                    end
                    if (got.trimmed !== exp_beat.trimmed)
                    begin
                        $display("%0t: trimmed mismatch: expected %0d, actual %0d",
                                 $time, exp_beat.trimmed, got.trimmed);
                        fail_count++;
                    end
                    if (got.mean_value !== exp_beat.mean_value)
                    begin
                        $display("%0t: mean_value mismatch: expected %0d, actual %0d",
                                 $time, exp_beat.mean_value, got.mean_value);
                        fail_count++;
                    end
                end
            end
            mean_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/swtm_pkg.sv
rtl/swtm_stream_if.sv
rtl/swtm_ctrl.sv
rtl/swtm_dp.sv
rtl/sliding_window_trimmed_mean.sv
test/tb.sv
